/* rtl/efme_pkg.sv */
// shared widths, codes, defaults and state type for the frame memory expansion block
package efme_pkg;

   localparam int ZONE_BYTES_DEF      = 67108864;
   localparam int MAX_FRAME_BYTES_DEF = 4194304;
   localparam int MAX_FRAMES_DEF      = 1024;

   localparam int ACTION_W   = 2;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 32;
   localparam int GAS_W      = 63;
   localparam int STATUS_W   = 2;
   localparam int FRAME_ID_W = 10;
   localparam int BASE_W     = 27;
   localparam int SIZE_W     = 23;

   localparam int WORD_BYTES = 32;
   localparam int WORD_SHIFT = 5;
   localparam int QUAD_SHIFT = 9;
   localparam int LIN_COST   = 3;

   localparam logic [ACTION_W-1:0] ACTION_CREATE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_DESTROY = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_ACCESS  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_GAS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STACK_ERR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FIN
   } state_type;

endpackage

/* rtl/efme_frame_mem.sv */
// frame table memory: start offset and byte size per frame, registered read
module efme_frame_mem
   import efme_pkg::*;
#(
   parameter int DEPTH   = MAX_FRAMES_DEF,
   parameter int START_W = BASE_W,
   parameter int BYTES_W = SIZE_W
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [START_W-1:0]       rd_start,
   output logic [BYTES_W-1:0]       rd_bytes,
   input  logic                     wr_start_en,
   input  logic                     wr_bytes_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [START_W-1:0]       wr_start,
   input  logic [BYTES_W-1:0]       wr_bytes
);

   logic [START_W-1:0] start_mem [DEPTH];
   logic [BYTES_W-1:0] bytes_mem [DEPTH];
   logic [START_W-1:0] rd_start_ff;
   logic [BYTES_W-1:0] rd_bytes_ff;

   always_ff @(posedge clock) begin
      if (wr_start_en) begin
         start_mem[wr_addr] <= wr_start;
      end
      if (wr_bytes_en) begin
         bytes_mem[wr_addr] <= wr_bytes;
      end
      if (rd_en) begin
         rd_start_ff <= start_mem[rd_addr];
         rd_bytes_ff <= bytes_mem[rd_addr];
      end
   end

   assign rd_start = rd_start_ff;
   assign rd_bytes = rd_bytes_ff;

endmodule

/* rtl/efme_cost.sv */
// expansion gas: registered word squares, then difference of 3w + w*w/512
module efme_cost
   import efme_pkg::*;
#(
   parameter int WORD_W = 17
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [WORD_W-1:0]     w_new,
   input  logic [WORD_W-1:0]     w_old,
   output logic [2*WORD_W:0]     delta
);

   localparam int CST_W = 2 * WORD_W + 1;

   logic [WORD_W-1:0]   wn_ff;
   logic [WORD_W-1:0]   wo_ff;
   logic [2*WORD_W-1:0] sqn_ff;
   logic [2*WORD_W-1:0] sqo_ff;
   logic [CST_W-1:0]    cost_new;
   logic [CST_W-1:0]    cost_old;

   always_ff @(posedge clock) begin
      if (load) begin
         wn_ff  <= w_new;
         wo_ff  <= w_old;
         sqn_ff <= w_new * w_new;
         sqo_ff <= w_old * w_old;
      end
   end

   assign cost_new = CST_W'(wn_ff) * CST_W'(LIN_COST) + CST_W'(sqn_ff >> QUAD_SHIFT);
   assign cost_old = CST_W'(wo_ff) * CST_W'(LIN_COST) + CST_W'(sqo_ff >> QUAD_SHIFT);
   assign delta    = cost_new - cost_old;

endmodule

/* rtl/evm_frame_memory_expansion_top.sv */
// top level: call-frame stack control, access checks and result register
//
// One transaction is taken when start is high and busy is low. The frame
// table is read at that edge, checks and word squares are formed in the
// next cycle, and the charge, table write-back and result follow in the
// cycle after, so busy drops as the result strobe rises. rsp_valid is
// high for one cycle and the result must be taken then; the receiver
// cannot stall. The registered table read, the registered word squares
// and the commit of the stack count and clean marks, which the next
// transaction needs, set the rate. The table needs no clearing after
// reset.
module evm_frame_memory_expansion_top
   import efme_pkg::*;
#(
   parameter int ZONE_BYTES      = ZONE_BYTES_DEF,
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int MAX_FRAMES      = MAX_FRAMES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [ADDR_W-1:0]     req_addr,
   input  logic [LEN_W-1:0]      req_len,
   input  logic [GAS_W-1:0]      req_gas,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [GAS_W-1:0]      rsp_gas_left,
   output logic [FRAME_ID_W-1:0] rsp_frame_id,
   output logic [BASE_W-1:0]     rsp_frame_base,
   output logic [SIZE_W-1:0]     rsp_frame_size,
   output logic [BASE_W-1:0]     rsp_clear_start,
   output logic [SIZE_W-1:0]     rsp_clear_len
);

   localparam int SW    = $clog2(ZONE_BYTES + 1);
   localparam int SZW   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int NW    = SZW + 2;
   localparam int WW    = SZW - WORD_SHIFT;
   localparam int DW    = 2 * WW + 1;
   localparam int IW    = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = ((SW > NW) ? SW : NW) + 1;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      calc_stage;
   logic      fin_stage;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [SW-1:0]       clean0_ff;
   logic [SW-1:0]       clean1_ff;
   logic [SW-1:0]       clean0_in;
   logic [SW-1:0]       clean1_in;
   logic [ACTION_W-1:0] action_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [GAS_W-1:0]    gas_ff;

   logic [CNT_W-1:0] rd_index;
   logic [SW-1:0]    rd_start;
   logic [SZW-1:0]   rd_bytes;

   logic [SW-1:0]    start_new_ff;
   logic [SW-1:0]    start_new_in;
   logic             over_ff;
   logic             over_in;
   logic             grow_ff;
   logic             grow_in;
   logic             lim_ff;
   logic             lim_in;
   logic [NW-1:0]    nsize_ff;
   logic [NW-1:0]    nsize_in;
   logic [SW-1:0]    es_ff;
   logic [SW-1:0]    ee_ff;
   logic [SUM_W-1:0] es_sum;
   logic [SUM_W-1:0] ee_sum;
   logic [NW-1:0]    need;
   logic [NW-1:0]    need_up;
   logic [SW:0]      clean_room;
   logic [SW-1:0]    clean_new;

   logic [DW-1:0]    delta;

   logic [CNT_W-1:0]    cur_idx;
   logic [SW-1:0]       clean_cur;
   logic [SW-1:0]       zero_end;
   logic                short_gas;
   logic                commit;
   logic                wr_start_en;
   logic                wr_bytes_en;
   logic [IW-1:0]       wr_addr;
   logic [SZW-1:0]      wr_bytes;

   logic [STATUS_W-1:0] fin_status;
   logic [GAS_W-1:0]    fin_gas;
   logic [CNT_W-1:0]    fin_id;
   logic [SW-1:0]       fin_base;
   logic [SZW-1:0]      fin_size;
   logic [SW-1:0]       fin_cs;
   logic [SZW-1:0]      fin_cl;

   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [GAS_W-1:0]    gas_left_ff;
   logic [FRAME_ID_W-1:0] id_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [BASE_W-1:0]   cs_ff;
   logic [SIZE_W-1:0]   cl_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      calc_stage = 1'b0;
      fin_stage  = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_CALC: calc_stage = 1'b1;
         ST_FIN:  fin_stage = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   assign accept = start && !busy;

   // grandparent on destroy and on a create onto a stack that is not full, current frame otherwise
   always_comb begin
      rd_index = count_ff - CNT_W'(1);
      if ((req_action == ACTION_CREATE && count_ff != CNT_W'(MAX_FRAMES)) ||
          req_action == ACTION_DESTROY) begin
         rd_index = count_ff - CNT_W'(2);
      end
   end

   efme_frame_mem #(
      .DEPTH   (MAX_FRAMES),
      .START_W (SW),
      .BYTES_W (SZW)
   ) u_frame_mem (
      .clock       (clock),
      .rd_en       (accept),
      .rd_addr     (rd_index[IW-1:0]),
      .rd_start    (rd_start),
      .rd_bytes    (rd_bytes),
      .wr_start_en (wr_start_en),
      .wr_bytes_en (wr_bytes_en),
      .wr_addr     (wr_addr),
      .wr_start    (start_new_ff),
      .wr_bytes    (wr_bytes)
   );

   // check stage
   always_comb begin
      clean_new    = count_ff[0] ? clean1_ff : clean0_ff;
      clean_room   = (SW+1)'(clean_new) + (SW+1)'(MAX_FRAME_BYTES);
      start_new_in = '0;
      if (clean_room < (SW+1)'(ZONE_BYTES)) begin
         start_new_in = clean_new;
      end else if (count_ff >= CNT_W'(2)) begin
         start_new_in = rd_start + SW'(rd_bytes);
      end
      over_in  = (addr_ff > ADDR_W'(MAX_FRAME_BYTES)) || (len_ff > LEN_W'(MAX_FRAME_BYTES));
      need     = NW'(addr_ff) + NW'(len_ff);
      grow_in  = need > NW'(rd_bytes);
      need_up  = need + NW'(WORD_BYTES - 1);
      nsize_in = {need_up[NW-1:WORD_SHIFT], WORD_SHIFT'(0)};
      ee_sum   = SUM_W'(rd_start) + SUM_W'(nsize_in);
      es_sum   = SUM_W'(rd_start) + SUM_W'(rd_bytes);
      lim_in   = (nsize_in > NW'(MAX_FRAME_BYTES)) || (ee_sum > SUM_W'(ZONE_BYTES));
   end

   efme_cost #(
      .WORD_W (WW)
   ) u_cost (
      .clock (clock),
      .load  (calc_stage),
      .w_new (nsize_in[SZW-1:WORD_SHIFT]),
      .w_old (rd_bytes[SZW-1:WORD_SHIFT]),
      .delta (delta)
   );

   // charge and commit stage
   always_comb begin
      cur_idx     = count_ff - CNT_W'(1);
      clean_cur   = cur_idx[0] ? clean1_ff : clean0_ff;
      zero_end    = (ee_ff < clean_cur) ? ee_ff : clean_cur;
      short_gas   = 64'(delta) > 64'(gas_ff);
      commit      = 1'b0;
      wr_start_en = 1'b0;
      wr_bytes_en = 1'b0;
      wr_addr     = cur_idx[IW-1:0];
      wr_bytes    = nsize_ff[SZW-1:0];
      count_in    = count_ff;
      clean0_in   = clean0_ff;
      clean1_in   = clean1_ff;
      fin_status  = STATUS_OK;
      fin_gas     = gas_ff;
      fin_id      = '0;
      fin_base    = '0;
      fin_size    = '0;
      fin_cs      = '0;
      fin_cl      = '0;
      case (action_ff)
         ACTION_CREATE: begin
            if (count_ff == CNT_W'(MAX_FRAMES)) begin
               fin_status = STATUS_STACK_ERR;
               fin_id     = cur_idx;
               fin_base   = rd_start;
               fin_size   = rd_bytes;
            end else begin
               wr_start_en = fin_stage;
               wr_bytes_en = fin_stage;
               wr_addr     = count_ff[IW-1:0];
               wr_bytes    = '0;
               count_in    = count_ff + CNT_W'(1);
               fin_id      = count_ff;
               fin_base    = start_new_ff;
            end
         end
         ACTION_DESTROY: begin
            if (count_ff == '0) begin
               fin_status = STATUS_STACK_ERR;
            end else begin
               count_in = cur_idx;
               if (count_ff != CNT_W'(1)) begin
                  fin_id   = count_ff - CNT_W'(2);
                  fin_base = rd_start;
                  fin_size = rd_bytes;
               end
            end
         end
         ACTION_ACCESS: begin
            if (count_ff == '0) begin
               fin_status = STATUS_STACK_ERR;
            end else begin
               fin_id   = cur_idx;
               fin_base = rd_start;
               fin_size = rd_bytes;
               if (len_ff != '0) begin
                  if (over_ff) begin
                     fin_status = STATUS_OUT_OF_GAS;
                  end else if (grow_ff) begin
                     if (lim_ff || short_gas) begin
                        fin_status = STATUS_OUT_OF_GAS;
                     end else begin
                        commit = 1'b1;
                     end
                  end
               end
            end
            if (commit) begin
               wr_bytes_en = fin_stage;
               fin_gas     = gas_ff - GAS_W'(delta);
               fin_size    = nsize_ff[SZW-1:0];
               if (zero_end > es_ff) begin
                  fin_cs = es_ff;
                  fin_cl = SZW'(zero_end - es_ff);
               end
               if (ee_ff > clean_cur) begin
                  if (cur_idx[0]) begin
                     clean1_in = ee_ff;
                  end else begin
                     clean0_in = ee_ff;
                  end
               end
            end
         end
         default: begin
            fin_status = STATUS_STACK_ERR;
            if (count_ff != '0) begin
               fin_id   = cur_idx;
               fin_base = rd_start;
               fin_size = rd_bytes;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         clean0_ff <= '0;
         clean1_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= fin_stage;
         if (fin_stage) begin
            count_ff  <= count_in;
            clean0_ff <= clean0_in;
            clean1_ff <= clean1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         addr_ff   <= req_addr;
         len_ff    <= req_len;
         gas_ff    <= req_gas;
      end
      if (calc_stage) begin
         start_new_ff <= start_new_in;
         over_ff      <= over_in;
         grow_ff      <= grow_in;
         lim_ff       <= lim_in;
         nsize_ff     <= nsize_in;
         es_ff        <= SW'(es_sum);
         ee_ff        <= SW'(ee_sum);
      end
      if (fin_stage) begin
         status_ff   <= fin_status;
         gas_left_ff <= fin_gas;
         id_ff       <= FRAME_ID_W'(fin_id);
         base_ff     <= BASE_W'(fin_base);
         size_ff     <= SIZE_W'(fin_size);
         cs_ff       <= BASE_W'(fin_cs);
         cl_ff       <= SIZE_W'(fin_cl);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_gas_left    = gas_left_ff;
   assign rsp_frame_id    = id_ff;
   assign rsp_frame_base  = base_ff;
   assign rsp_frame_size  = size_ff;
   assign rsp_clear_start = cs_ff;
   assign rsp_clear_len   = cl_ff;

endmodule
